[design/bdh_pkg.sv]
// Package: shared word types, event codes and the lockout reset constant of the debounce block.
`timescale 1ns / 1ps

package bdh_pkg;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_HOLD    = 2'd3;

	localparam logic [15:0] LOCKOUT_RESET = 16'd50;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [31:0] encoder_count;
		logic               level_a;
		logic               level_sw;
	} poll_word_t;

	typedef struct packed {
		logic signed [31:0] encoder_delta;
		logic [1:0]         event_a;
		logic [31:0]        held_ms_a;
		logic [1:0]         event_sw;
		logic [31:0]        held_ms_sw;
	} result_word_t;

	typedef struct packed {
		logic [1:0]  ev;
		logic [31:0] held_ms;
	} btn_result_t;

endpackage

[design/bdh_button.sv]
// One debounced button: lockout check, press tracking and event generation.
`timescale 1ns / 1ps

module bdh_button (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [31:0]          now_ms,
	input  logic                 level,
	input  logic [15:0]          lockout_ms,
	output bdh_pkg::btn_result_t result
);

	logic        accepted_level_q;
	logic [31:0] change_time_q;
	logic        pressed_q;
	logic [31:0] press_start_q;

	logic [31:0] since_change;
	logic [31:0] since_press;
	logic        take_change;

	assign since_change = now_ms - change_time_q;
	assign since_press  = now_ms - press_start_q;
	assign take_change  = (level != accepted_level_q) &&
	                      (since_change > {16'd0, lockout_ms});

	always_comb begin
		result.ev      = bdh_pkg::EV_NONE;
		result.held_ms = 32'd0;
		if (take_change) begin
			if (!level && !pressed_q) begin
				result.ev = bdh_pkg::EV_PRESS;
			end else if (level && pressed_q) begin
				result.ev      = bdh_pkg::EV_RELEASE;
				result.held_ms = since_press;
			end
		end else if (pressed_q) begin
			result.ev      = bdh_pkg::EV_HOLD;
			result.held_ms = since_press;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_level_q <= 1'b1;
			change_time_q    <= 32'd0;
			pressed_q        <= 1'b0;
			press_start_q    <= 32'd0;
		end else if (advance && take_change) begin
			change_time_q    <= now_ms;
			accepted_level_q <= level;
			if (!level && !pressed_q) begin
				pressed_q     <= 1'b1;
				press_start_q <= now_ms;
			end else if (level && pressed_q) begin
				pressed_q <= 1'b0;
			end
		end
	end

endmodule

[design/button_debounce_hold_timer.sv]
// Top level: poll input register, encoder delta, two debounced buttons, result register.
`timescale 1ns / 1ps

// Usage
//   poll channel   (poll_valid / poll_ready / poll): one word per sampling tick,
//                  carrying the millisecond timestamp, encoder count and the two
//                  active-low raw button levels.
//   result channel (result_valid / result_ready / result): exactly one word per
//                  poll, in order: encoder delta plus an event and held time for
//                  button A and for the encoder switch.
//   cfg_we / cfg_wdata: write lockout_ms (reset value 50); write only while idle.
// Path: a poll waits in the input register and moves into the result register once that is free.
// Throughput: one poll per cycle while result_ready stays high; set by the input register feeding
// the single compare/subtract stage in front of the result register.
// Reset: all debounce state returns to released, change and press times to 0,
// previous count to 0; the lockout also covers the first polls after reset.
// Stall: while result_ready is low the result register holds its word and the
// input register can still take one more poll; poll_ready drops only when both
// registers hold words.

module button_debounce_hold_timer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll_valid,
	output logic                  poll_ready,
	input  bdh_pkg::poll_word_t   poll,
	output logic                  result_valid,
	input  logic                  result_ready,
	output bdh_pkg::result_word_t result,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata
);

	logic                  valid_s1;
	bdh_pkg::poll_word_t   poll_s1;
	logic                  valid_s2;
	bdh_pkg::result_word_t result_s2;

	logic [15:0]        lockout_q;
	logic signed [31:0] prev_count_q;

	logic                 advance;
	bdh_pkg::btn_result_t res_a;
	bdh_pkg::btn_result_t res_sw;

	// Move the stage-1 word into the result register when that slot frees up.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign poll_ready = !valid_s1 || advance;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= bdh_pkg::LOCKOUT_RESET;
		end else if (cfg_we) begin
			lockout_q <= cfg_wdata;
		end
	end

	// Input register: hold the poll until it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_ready && poll_valid) begin
			poll_s1 <= poll;
		end
	end

	bdh_button u_btn_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.now_ms     (poll_s1.now_ms),
		.level      (poll_s1.level_a),
		.lockout_ms (lockout_q),
		.result     (res_a)
	);

	bdh_button u_btn_sw (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.now_ms     (poll_s1.now_ms),
		.level      (poll_s1.level_sw),
		.lockout_ms (lockout_q),
		.result     (res_sw)
	);

	// Previous encoder count advances together with the button state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= 32'sd0;
		end else if (advance) begin
			prev_count_q <= poll_s1.encoder_count;
		end
	end

	// Result register: drop the word once taken, load when stage 1 advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.encoder_delta <= poll_s1.encoder_count - prev_count_q;
			result_s2.event_a       <= res_a.ev;
			result_s2.held_ms_a     <= res_a.held_ms;
			result_s2.event_sw      <= res_sw.ev;
			result_s2.held_ms_sw    <= res_sw.held_ms;
		end
	end

endmodule

[design/bdh_checker.sv]
// Checker: port-level assertions for the debounce block, bound to its top level.
`timescale 1ns / 1ps

module bdh_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_ready,
	input bdh_pkg::result_word_t result
);

	logic out_acc;
	logic pressed_a_q;
	logic pressed_sw_q;

	assign out_acc = result_valid && result_ready;

	// Track whether each button is held, as seen from delivered words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_a_q  <= 1'b0;
			pressed_sw_q <= 1'b0;
		end else if (out_acc) begin
			pressed_a_q  <= (result.event_a == bdh_pkg::EV_PRESS) ||
			                (result.event_a == bdh_pkg::EV_HOLD);
			pressed_sw_q <= (result.event_sw == bdh_pkg::EV_PRESS) ||
			                (result.event_sw == bdh_pkg::EV_HOLD);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_a == bdh_pkg::EV_NONE ||
		                 result.event_a == bdh_pkg::EV_PRESS) |->
		result.held_ms_a == 32'd0)
		else $error("held_ms_a nonzero on none or press");

	a_seq_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pressed_a_q ?
			(result.event_a == bdh_pkg::EV_RELEASE || result.event_a == bdh_pkg::EV_HOLD) :
			(result.event_a == bdh_pkg::EV_PRESS || result.event_a == bdh_pkg::EV_NONE)))
		else $error("button A event out of sequence");

	a_seq_sw: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pressed_sw_q ?
			(result.event_sw == bdh_pkg::EV_RELEASE || result.event_sw == bdh_pkg::EV_HOLD) :
			(result.event_sw == bdh_pkg::EV_PRESS || result.event_sw == bdh_pkg::EV_NONE)))
		else $error("switch event out of sequence");

endmodule

bind button_debounce_hold_timer bdh_checker u_bdh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

[sim/tb.sv]
// Testbench for the debounce and hold-timer block: directed and random polls checked word by word.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int BTN_A        = 0;
	localparam int BTN_SW       = 1;
	localparam int ITEMS_PER_SET = 300;
	localparam int PRINT_CAP    = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  poll_valid;
	logic                  poll_ready;
	bdh_pkg::poll_word_t   poll;
	logic                  result_valid;
	logic                  result_ready;
	bdh_pkg::result_word_t result;
	logic                  cfg_we;
	logic [15:0]           cfg_wdata;

	// Predictor state: encoder history, lockout setting and per-button debounce state.
	logic [31:0]  last_count;
	logic [15:0]  lockout_setting;
	logic         btn_level  [2];
	logic [31:0]  btn_change [2];
	logic         btn_pressed[2];
	logic [31:0]  btn_start  [2];

	// Words the block still owes, oldest first.
	bdh_pkg::result_word_t expected_results[$];

	int error_count;
	int result_count;
	int cycle_count;

	// Flow control knobs shared between the stimulus and the receiver.
	bit sender_idle;
	bit ready_random;
	int hold_request;
	int stall_left;
	int ready_pick;

	// Random stimulus tracking: running timestamp, count and intended levels.
	logic [31:0]  now_track;
	logic [31:0]  count_track;
	logic         want_a;
	logic         want_sw;

	button_debounce_hold_timer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_ready   (poll_ready),
		.poll         (poll),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Bound the run; a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d words still expected",
				cycle_count, expected_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void reset_model();
		last_count      = '0;
		lockout_setting = bdh_pkg::LOCKOUT_RESET;
		for (int i = 0; i < 2; i++) begin
			btn_level[i]   = 1'b1;
			btn_change[i]  = '0;
			btn_pressed[i] = 1'b0;
			btn_start[i]   = '0;
		end
	endfunction

	// Debounce one button for one poll and update its state.
	function automatic bdh_pkg::btn_result_t debounce_step(input int idx,
		input logic [31:0] now, input logic lvl);
		bdh_pkg::btn_result_t r;
		logic [31:0] since;
		r.ev      = bdh_pkg::EV_NONE;
		r.held_ms = '0;
		since     = now - btn_change[idx];
		if (lvl != btn_level[idx] && since > {16'd0, lockout_setting}) begin
			// Accept the new level and restart the lockout window.
			btn_change[idx] = now;
			btn_level[idx]  = lvl;
			if (!lvl && !btn_pressed[idx]) begin
				r.ev             = bdh_pkg::EV_PRESS;
				btn_pressed[idx] = 1'b1;
				btn_start[idx]   = now;
			end else if (lvl && btn_pressed[idx]) begin
				r.ev             = bdh_pkg::EV_RELEASE;
				r.held_ms        = now - btn_start[idx];
				btn_pressed[idx] = 1'b0;
			end
		end else if (btn_pressed[idx]) begin
			// Still held, either steady or bouncing inside the lockout.
			r.ev      = bdh_pkg::EV_HOLD;
			r.held_ms = now - btn_start[idx];
		end
		return r;
	endfunction

	function automatic bdh_pkg::result_word_t predict_poll(input bdh_pkg::poll_word_t p);
		bdh_pkg::result_word_t w;
		bdh_pkg::btn_result_t  ba;
		bdh_pkg::btn_result_t  bs;
		w.encoder_delta = p.encoder_count - last_count;
		last_count      = p.encoder_count;
		ba              = debounce_step(BTN_A, p.now_ms, p.level_a);
		bs              = debounce_step(BTN_SW, p.now_ms, p.level_sw);
		w.event_a       = ba.ev;
		w.held_ms_a     = ba.held_ms;
		w.event_sw      = bs.ev;
		w.held_ms_sw    = bs.held_ms;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (error_count < PRINT_CAP)
			$display("MISMATCH word %0d %s: got %h expected %h", result_count, what, got, want);
		error_count++;
	endtask

	// Compare each accepted result word against the oldest expectation.
	always @(posedge clk) begin : result_check
		bdh_pkg::result_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("word with nothing expected", result.encoder_delta, '0);
			end else begin
				want = expected_results.pop_front();
				if (result.encoder_delta !== want.encoder_delta)
					report_mismatch("encoder_delta", result.encoder_delta, want.encoder_delta);
				if (result.event_a !== want.event_a)
					report_mismatch("event_a", {30'd0, result.event_a}, {30'd0, want.event_a});
				if (result.held_ms_a !== want.held_ms_a)
					report_mismatch("held_ms_a", result.held_ms_a, want.held_ms_a);
				if (result.event_sw !== want.event_sw)
					report_mismatch("event_sw", {30'd0, result.event_sw}, {30'd0, want.event_sw});
				if (result.held_ms_sw !== want.held_ms_sw)
					report_mismatch("held_ms_sw", result.held_ms_sw, want.held_ms_sw);
			end
			result_count++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: drive result_ready, honoring a requested hold-off first
	// ------------------------------------------------------------------

	initial begin
		result_ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(posedge clk);
			// Take a long hold-off request; it overrides the random pattern.
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!ready_random) begin
				result_ready <= 1'b1;
			end else begin
				// Mostly ready, short stalls often, long stalls rarely.
				ready_pick = $urandom_range(0, 99);
				if (ready_pick < 70) begin
					result_ready <= 1'b1;
				end else if (ready_pick < 95) begin
					stall_left   = $urandom_range(1, 3) - 1;
					result_ready <= 1'b0;
				end else begin
					stall_left   = $urandom_range(10, 50) - 1;
					result_ready <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender and configuration
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		if (!sender_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one poll word, hold it until taken, then predict its result.
	// Called right after a rising edge; returns right after one.
	task automatic send_poll(input bdh_pkg::poll_word_t w);
		int gap;
		poll       <= w;
		poll_valid <= 1'b1;
		do @(posedge clk); while (!poll_ready);
		expected_results.push_back(predict_poll(w));
		gap = pick_gap();
		if (gap > 0) begin
			poll_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every owed word to come out.
	task automatic wait_idle();
		poll_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Write the lockout register while the block is idle.
	task automatic write_lockout(input logic [15:0] value);
		wait_idle();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lockout_setting = value;
	endtask

	function automatic bdh_pkg::poll_word_t make_poll(input logic [31:0] now,
		input logic [31:0] count, input logic lvl_a, input logic lvl_sw);
		bdh_pkg::poll_word_t w;
		w.now_ms        = now;
		w.encoder_count = count;
		w.level_a       = lvl_a;
		w.level_sw      = lvl_sw;
		return w;
	endfunction

	// Build a plausible poll: advancing time, small encoder moves, buttons that
	// change intent now and then and bounce a little. Some polls jump anywhere.
	function automatic bdh_pkg::poll_word_t next_random_poll(input int lk);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			now_track = now_track + $urandom_range(0, lk / 4 + 5);
		else if (r < 95)
			now_track = now_track + $urandom_range(lk / 2, lk * 2 + 10);
		else
			now_track = $urandom;
		r = $urandom_range(0, 99);
		if (r < 85)
			count_track = count_track + $urandom_range(0, 20) - 10;
		else
			count_track = $urandom;
		if ($urandom_range(0, 9) == 0)
			want_a = ~want_a;
		if ($urandom_range(0, 9) == 0)
			want_sw = ~want_sw;
		return make_poll(now_track, count_track,
			want_a ^ ($urandom_range(0, 9) == 0),
			want_sw ^ ($urandom_range(0, 9) == 0));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset lockout, encoder extremes, press, hold, bounce and release at lockout 50.
	task automatic test_reset_lockout();
		sender_idle  = 1'b1;
		ready_random = 1'b1;
		// Changes inside the lockout that starts at time zero are dropped.
		send_poll(make_poll(32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0));
		send_poll(make_poll(32'd50, 32'h8000_0000, 1'b0, 1'b1));
		// First poll past the window: both buttons press.
		send_poll(make_poll(32'd51, 32'hFFFF_FFFF, 1'b0, 1'b0));
		// Bounce inside the window while pressed: hold.
		send_poll(make_poll(32'd60, 32'h0000_0000, 1'b1, 1'b0));
		send_poll(make_poll(32'd101, 32'd5, 1'b0, 1'b0));
		// Release A just past the window; switch keeps holding.
		send_poll(make_poll(32'd102, 32'h7FFF_FFFF, 1'b1, 1'b0));
		// A bounces back inside its window while released: no event.
		send_poll(make_poll(32'd103, 32'h8000_0001, 1'b0, 1'b1));
	endtask

	// Lockout at zero and at full scale, with timestamps that wrap.
	task automatic test_lockout_extremes();
		sender_idle  = 1'b1;
		ready_random = 1'b1;
		write_lockout(16'd0);
		// One elapsed millisecond clears a zero lockout: A presses.
		send_poll(make_poll(32'd103, 32'h0000_0000, 1'b0, 1'b1));
		send_poll(make_poll(32'd104, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_poll(make_poll(32'd105, 32'h5555_5555, 1'b1, 1'b1));
		write_lockout(16'hFFFF);
		send_poll(make_poll(32'hFFFF_FFF0, 32'hAAAA_AAAA, 1'b0, 1'b1));
		// Time wraps past zero: A holds, switch presses.
		send_poll(make_poll(32'h0000_0010, 32'h0000_0001, 1'b1, 1'b0));
		// Exactly 65536 elapsed since the A press: release.
		send_poll(make_poll(32'h0000_FFF0, 32'h8000_0000, 1'b1, 1'b0));
		send_poll(make_poll(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1));
		write_lockout(bdh_pkg::LOCKOUT_RESET);
		send_poll(make_poll(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0));
	endtask

	// Hold the receiver off for a long stretch while polls keep coming, so the
	// block fills both registers and drops poll_ready.
	task automatic test_backpressure();
		sender_idle  = 1'b0;
		ready_random = 1'b0;
		hold_request = 200;
		for (int i = 0; i < 16; i++)
			send_poll(next_random_poll(lockout_setting));
		wait_idle();
	endtask

	// Random polls over several lockout settings and flow-control mixes.
	task automatic test_random_polls();
		logic [15:0] settings[6];
		settings[0] = 16'd0;
		settings[1] = 16'hFFFF;
		settings[2] = bdh_pkg::LOCKOUT_RESET;
		settings[3] = 16'd1;
		settings[4] = 16'($urandom_range(2, 1000));
		settings[5] = 16'($urandom);
		for (int s = 0; s < 6; s++) begin
			write_lockout(settings[s]);
			// First set runs with no idling on either side.
			sender_idle  = (s % 3 != 0);
			ready_random = (s % 2 != 0);
			for (int i = 0; i < ITEMS_PER_SET; i++)
				send_poll(next_random_poll(settings[s]));
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		poll_valid   = 1'b0;
		poll         = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		sender_idle  = 1'b0;
		ready_random = 1'b0;
		hold_request = 0;
		error_count  = 0;
		result_count = 0;
		cycle_count  = 0;
		now_track    = '0;
		count_track  = '0;
		want_a       = 1'b1;
		want_sw      = 1'b1;
		reset_model();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_lockout();
		test_lockout_extremes();
		test_backpressure();
		test_random_polls();

		// Drain, then keep the clock running so the pipeline can show any stray word.
		wait_idle();
		repeat (4) @(posedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[button_debounce_hold_timer.f]
design/bdh_pkg.sv
design/bdh_button.sv
design/button_debounce_hold_timer.sv
design/bdh_checker.sv
sim/tb.sv
